FILE: rtl/sha_pkg.sv
package sha_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_INIT,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // flags from the sequencer to the round core
  typedef struct packed {
    logic load;
    logic step;
    logic fold;
  } core_ctl_t;

  localparam word_t PadWord = 32'h8000_0000;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_value(input logic mode, input logic [2:0] i);
    word_t v;
    unique case (i)
      3'd0: v = mode ? 32'hc1059ed8 : 32'h6a09e667;
      3'd1: v = mode ? 32'h367cd507 : 32'hbb67ae85;
      3'd2: v = mode ? 32'h3070dd17 : 32'h3c6ef372;
      3'd3: v = mode ? 32'hf70e5939 : 32'ha54ff53a;
      3'd4: v = mode ? 32'hffc00b31 : 32'h510e527f;
      3'd5: v = mode ? 32'h68581511 : 32'h9b05688c;
      3'd6: v = mode ? 32'h64f98fa7 : 32'h1f83d9ab;
      default: v = mode ? 32'hbefa4fa4 : 32'h5be0cd19;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/sha_round_core.sv
module sha_round_core
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       init_chain,
  input  logic       mode,
  input  core_ctl_t  ctl,
  input  logic [5:0] round,
  input  logic       wr_en,
  input  logic [3:0] wr_addr,
  input  word_t      wr_data,
  input  logic [2:0] out_sel,
  output word_t      out_word
);

  word_t chain_r [8];
  word_t regs_r [8];
  word_t win_r [16];
  word_t w, x2, x15, s1, ch, t1, s0, mj, sg0, sg1, wnew;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  // message schedule: rolling window, a new word from round 16 on
  always_comb begin
    x2   = win_r[4'(round - 6'd2)];
    x15  = win_r[4'(round - 6'd15)];
    sg1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    sg0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    wnew = sg1 + win_r[4'(round - 6'd7)] + sg0 + win_r[round[3:0]];
    w    = (round >= 6'd16) ? wnew : win_r[round[3:0]];
  end

  // one compression round
  always_comb begin
    s1 = rotr(regs_r[4], 6) ^ rotr(regs_r[4], 11) ^ rotr(regs_r[4], 25);
    ch = (regs_r[4] & regs_r[5]) ^ (~regs_r[4] & regs_r[6]);
    t1 = regs_r[7] + s1 + ch + round_k(round) + w;
    s0 = rotr(regs_r[0], 2) ^ rotr(regs_r[0], 13) ^ rotr(regs_r[0], 22);
    mj = (regs_r[0] & regs_r[1]) ^ (regs_r[0] & regs_r[2]) ^ (regs_r[1] & regs_r[2]);
  end

  // window writes from the loader or the schedule
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_r[wr_addr] <= wr_data;
    end else if (ctl.step && round >= 6'd16) begin
      win_r[round[3:0]] <= wnew;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) regs_r[i] <= '0;
    end else if (ctl.load) begin
      for (int i = 0; i < 8; i++) regs_r[i] <= chain_r[i];
    end else if (ctl.step) begin
      regs_r[0] <= t1 + s0 + mj;
      regs_r[1] <= regs_r[0];
      regs_r[2] <= regs_r[1];
      regs_r[3] <= regs_r[2];
      regs_r[4] <= regs_r[3] + t1;
      regs_r[5] <= regs_r[4];
      regs_r[6] <= regs_r[5];
      regs_r[7] <= regs_r[6];
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (!rst_n || init_chain) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= init_value(rst_n ? mode : 1'b0, 3'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + regs_r[i];
    end
  end

  assign out_word = chain_r[out_sel];

endmodule

FILE: rtl/sha256_hash_engine_unit.sv
// sha-256 / sha-224 hash engine
// input stream: one big-endian 32-bit message word per transaction; in_tdata holds
// the word, in_tuser the count of valid bytes (0..4, upper first), in_tlast ends the
// message. only the final word may be short; an empty final transaction is legal.
// output stream: eight digest words (seven in sha-224 mode) after the final word,
// out_tlast marks the last one. the engine then restarts for the next message.
// cfg_we/cfg_wdata write digest_mode (0 sha-256, 1 sha-224) and reset the chaining value, length and position;
// write only while idle.
// throughput: one word is taken per cycle while idle; every sixteenth word starts a block
// compression of 64 rounds plus load and fold, during which in_tready is low. the
// round unit is a single shared adder chain stepped once per cycle.
// the final word adds padding: one pad word loaded per cycle, plus one or two
// compressions, then one digest word per cycle unless out_tready stalls; out_tvalid
// holds and the engine waits; nothing else moves until the digest is drained.
// reset (synchronous, rst_n low) selects sha-256 and clears length and position.
module sha256_hash_engine_unit
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // digest_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // message_word
  input  logic [2:0]  in_tuser,      // valid_bytes
  input  logic        in_tlast,      // message_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // digest_word
  output logic        out_tlast      // digest_last
);

  state_t state_r, state_nxt;
  logic        mode_r;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        fin_r, fin_nxt;      // padding in progress
  logic        lenw_r, lenw_nxt;    // length words may go in this block
  logic        pend_r, pend_nxt;    // pad word still owed after a full last word
  logic        lenblk_r;            // block just compressed held the length
  core_ctl_t   ctl;
  logic        wr_en, init_chain;
  word_t       wr_data, digest;
  logic [2:0]  nb;
  logic        acc;

  assign acc = in_tvalid && in_tready;
  assign nb  = (in_tuser > 3'd4) ? 3'd4 : in_tuser;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      len_r   <= '0;
      round_r <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      lenw_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      round_r <= round_nxt;
      oidx_r  <= oidx_nxt;
      fin_r   <= fin_nxt;
      lenw_r  <= lenw_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    round_nxt  = round_r;
    oidx_nxt   = oidx_r;
    fin_nxt    = fin_r;
    lenw_nxt   = lenw_r;
    pend_nxt   = pend_r;
    ctl        = '0;
    wr_en      = 1'b0;
    wr_data    = in_tdata;
    init_chain = cfg_we;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (acc) begin
          wr_en   = 1'b1;
          pos_nxt = pos_r + 4'd1;
          if (!in_tlast) begin
            len_nxt = len_r + 64'd32;
            if (pos_r == 4'd15) state_nxt = ST_INIT;
          end else begin
            len_nxt = len_r + {58'd0, nb, 3'd0};
            fin_nxt = 1'b1;
            unique case (nb)
              3'd0: wr_data = PadWord;
              3'd1: wr_data = {in_tdata[31:24], 24'h800000};
              3'd2: wr_data = {in_tdata[31:16], 16'h8000};
              3'd3: wr_data = {in_tdata[31:8], 8'h80};
              default: wr_data = in_tdata;
            endcase
            // full last word still needs its own pad word
            pend_nxt  = (nb == 3'd4);
            // length fits behind the pad word only up to position 13
            lenw_nxt  = (nb != 3'd4) && (pos_r < 4'd14);
            state_nxt = (pos_r == 4'd15) ? ST_INIT : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        pos_nxt = pos_r + 4'd1;
        if (pend_r) begin
          wr_data  = PadWord;
          pend_nxt = 1'b0;
          lenw_nxt = (pos_r < 4'd14);
        end else if (lenw_r && pos_r == 4'd14) begin
          wr_data = len_r[63:32];
        end else if (lenw_r && pos_r == 4'd15) begin
          wr_data = len_r[31:0];
        end else begin
          wr_data = '0;
        end
        if (pos_r == 4'd15) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        ctl.load  = 1'b1;
        round_nxt = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        ctl.step  = 1'b1;
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (lenblk_r) begin
          state_nxt = ST_EMIT;
          oidx_nxt  = '0;
        end else begin
          lenw_nxt  = 1'b1;
          state_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (out_tlast) begin
            init_chain = 1'b1;
            state_nxt  = ST_IDLE;
            pos_nxt    = '0;
            len_nxt    = '0;
            fin_nxt    = 1'b0;
            lenw_nxt   = 1'b0;
            pend_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      pos_nxt = '0;
      len_nxt = '0;
    end
  end

  // length words went in if the block finished from the length-writing pad path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lenblk_r <= 1'b0;
    end else if (state_r == ST_PAD) begin
      lenblk_r <= lenw_r && pos_r == 4'd15;
    end else if (state_r == ST_IDLE) begin
      lenblk_r <= 1'b0;
    end
  end

  sha_round_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .init_chain (init_chain),
    .mode       (cfg_we ? cfg_wdata : mode_r),
    .ctl        (ctl),
    .round      (round_r),
    .wr_en      (wr_en),
    .wr_addr    (pos_r),
    .wr_data    (wr_data),
    .out_sel    (oidx_r),
    .out_word   (digest)
  );

  assign out_tdata = digest;
  assign out_tlast = (oidx_r == (mode_r ? 3'd6 : 3'd7));

  // checks
  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("output while accepting input");
  a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r == 6'd63) |=> state_r == ST_FOLD)
    else $error("round count broken");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(oidx_r))
    else $error("digest dropped under stall");
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_tready && out_tlast) |=> pos_r == 4'd0)
    else $error("position not cleared after digest");

endmodule
